>>> src/dlrf_pkg.sv
// Shared types, packet constants and byte-selection helpers for the debug-link
// request framer. No dependencies.
package dlrf_pkg;

   localparam logic [7:0] HDR_SYNC  = 8'hAD;
   localparam logic [7:0] HDR_ZERO  = 8'h00;
   localparam logic [7:0] HDR_MARK  = 8'hFF;
   localparam logic [7:0] LEN_READ  = 8'h07;
   localparam logic [7:0] LEN_WRITE = 8'h0A;
   localparam logic [7:0] CMD_READ  = 8'h02;
   localparam logic [7:0] CMD_WRITE = 8'h82;
   localparam logic [7:0] ESC_BYTE  = 8'h5C;
   localparam logic [7:0] XON_BYTE  = 8'h11;
   localparam logic [7:0] XOFF_BYTE = 8'h13;
   localparam logic [7:0] ESC_FLIP  = 8'hFF;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam int unsigned IDX_W = 4;

   localparam logic [IDX_W-1:0] LAST_READ  = 4'd10;
   localparam logic [IDX_W-1:0] LAST_WRITE = 4'd13;

   // One classified request as it waits between front and back.
   typedef struct packed {
      logic        is_write;
      logic [31:0] address;
      logic [31:0] payload;   // write data, or the counter in the low byte
      logic [7:0]  checksum;
   } pkt_desc_type;

   function automatic logic [IDX_W-1:0] last_index(input pkt_desc_type d);
      return d.is_write ? LAST_WRITE : LAST_READ;
   endfunction

   function automatic logic is_escape(input logic [7:0] b);
      return (b == XON_BYTE) || (b == XOFF_BYTE) || (b == ESC_BYTE);
   endfunction

   // Raw (unescaped) packet byte at position idx.
   function automatic logic [7:0] raw_byte(input pkt_desc_type d,
                                           input logic [IDX_W-1:0] idx);
      logic [7:0] b;
      b = HDR_ZERO;
      if (idx == last_index(d)) begin
         b = d.checksum;
      end else begin
         unique case (idx)
            4'd0:    b = HDR_SYNC;
            4'd1:    b = HDR_ZERO;
            4'd2:    b = d.is_write ? LEN_WRITE : LEN_READ;
            4'd3:    b = HDR_MARK;
            4'd4:    b = d.is_write ? CMD_WRITE : CMD_READ;
            4'd5:    b = d.address[7:0];
            4'd6:    b = d.address[15:8];
            4'd7:    b = d.address[23:16];
            4'd8:    b = d.address[31:24];
            4'd9:    b = d.payload[7:0];
            4'd10:   b = d.payload[15:8];
            4'd11:   b = d.payload[23:16];
            4'd12:   b = d.payload[31:24];
            default: b = HDR_ZERO;
         endcase
      end
      return b;
   endfunction

endpackage

>>> src/dlrf_front.sv
// Front end of the framer: accepts requests, keeps the read counter and
// builds the packet descriptor with its checksum. Depends on dlrf_pkg.
module dlrf_front import dlrf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic         full,
   input  logic         req_opcode,
   input  logic [31:0]  req_address,
   input  logic [31:0]  req_write_data,
   output logic         wr_en,
   output pkt_desc_type wr_desc
);

   logic [7:0]  counter_ff;
   logic [7:0]  counter_in;
   logic [7:0]  cnt_next;
   logic [31:0] payload;
   logic [7:0]  cmd;

   assign wr_en    = push && !full;
   assign cnt_next = counter_ff + 8'd1;
   assign payload  = (req_opcode == OP_WRITE) ? req_write_data : {24'd0, cnt_next};
   assign cmd      = (req_opcode == OP_WRITE) ? CMD_WRITE : CMD_READ;

   // Advance the counter only on an accepted read.
   assign counter_in = (wr_en && req_opcode == OP_READ) ? cnt_next : counter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= 8'd0;
      end else begin
         counter_ff <= counter_in;
      end
   end

   always_comb begin
      wr_desc.is_write = (req_opcode == OP_WRITE);
      wr_desc.address  = req_address;
      wr_desc.payload  = payload;
      wr_desc.checksum = HDR_MARK ^ cmd
                       ^ req_address[7:0] ^ req_address[15:8]
                       ^ req_address[23:16] ^ req_address[31:24]
                       ^ payload[7:0] ^ payload[15:8]
                       ^ payload[23:16] ^ payload[31:24];
   end

`ifndef NO_ASSERTIONS
   a_read_counts: assert property (@(posedge clock) disable iff (reset)
      (wr_en && req_opcode == OP_READ) |=> (counter_ff == $past(counter_ff) + 8'd1))
      else $error("read counter did not advance");
   a_write_holds: assert property (@(posedge clock) disable iff (reset)
      !(wr_en && req_opcode == OP_READ) |=> $stable(counter_ff))
      else $error("read counter moved without a read");
   a_read_payload: assert property (@(posedge clock)
      (req_opcode == OP_READ) |-> (wr_desc.payload[31:8] == 24'd0))
      else $error("read payload upper bytes not zero");
`endif

endmodule

>>> src/dlrf_queue.sv
// Small descriptor queue between front and back of the framer.
// Depends on dlrf_pkg.
module dlrf_queue import dlrf_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         wr_en,
   input  pkt_desc_type wr_desc,
   input  logic         rd_en,
   output pkt_desc_type rd_desc,
   output logic         q_full,
   output logic         q_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   pkt_desc_type     slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   assign q_full  = (count_ff == CNT_FULL);
   assign q_empty = (count_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_desc = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_desc;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count over depth");
   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      (q_empty || q_full) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_full && !do_rd) |=> q_full)
      else $error("full queue lost an entry");
`endif

endmodule

>>> src/dlrf_back.sv
// Back end of the framer: walks the raw packet bytes of the head descriptor,
// inserts escapes and feeds the response output register. Depends on dlrf_pkg.
module dlrf_back import dlrf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  pkt_desc_type head_desc,
   output logic         head_pop,
   input  logic         pop,
   output logic         empty,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_last
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             esc_ff, esc_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             out_last_ff, out_last_in;
   logic             can_load;
   logic             emit;
   logic [7:0]       raw;
   logic             at_last;

   assign can_load = !out_valid_ff || pop;
   assign emit     = can_load && head_valid;
   assign raw      = raw_byte(head_desc, idx_ff);
   assign at_last  = (idx_ff == last_index(head_desc));

   always_comb begin
      idx_in       = idx_ff;
      esc_in       = esc_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !pop;
      head_pop     = 1'b0;
      if (emit) begin
         out_valid_in = 1'b1;
         if (is_escape(raw) && !esc_ff) begin
            // Send the escape marker first, hold the byte index.
            out_byte_in = ESC_BYTE;
            out_last_in = 1'b0;
            esc_in      = 1'b1;
         end else begin
            out_byte_in = esc_ff ? (raw ^ ESC_FLIP) : raw;
            out_last_in = at_last;
            esc_in      = 1'b0;
            idx_in      = at_last ? '0 : idx_ff + 1'b1;
            head_pop    = at_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         esc_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         esc_ff       <= esc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign empty        = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_last     = out_last_ff;

`ifndef NO_ASSERTIONS
   a_esc_pending: assert property (@(posedge clock) disable iff (reset)
      esc_ff |-> (head_valid && is_escape(raw)))
      else $error("escape pending without an escapable head byte");
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (idx_ff <= last_index(head_desc)))
      else $error("byte index past end of packet");
   a_idle_idx: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> (idx_ff == '0 && !esc_ff))
      else $error("serializer not at packet start while idle");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("response side not empty after reset");
`endif

endmodule

>>> src/debug_link_request_framer.sv
// Top level of the debug-link request framer: front end, descriptor queue and
// escaping serializer. Depends on dlrf_pkg, dlrf_front, dlrf_queue, dlrf_back.
//
//   channel    handshake          payload                                   unit
//   ---------  -----------------  ----------------------------------------  -------
//   request    push / full        req_opcode, req_address, req_write_data   1 pkt
//   response   empty / pop        rsp_out_byte, rsp_last                    1 byte
//
// The serializer sends one wire byte per cycle while pop stays high and a
// request is queued; a packet is 11 to 17 bytes (read) or 14 to 23 (write)
// after escaping. A request is taken in any cycle the queue has room; the
// first byte of an idle block goes through a queue slot, then the output
// register. Reset is synchronous and clears the read counter, the queue and
// the output register. A stalled response side holds its byte and fills the
// queue, then full rises; the request side never stalls the response side.
module debug_link_request_framer import dlrf_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        push,
   output logic        full,
   input  logic        req_opcode,
   input  logic [31:0] req_address,
   input  logic [31:0] req_write_data,
   // response side
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last
);

   logic         wr_en;
   pkt_desc_type wr_desc;
   pkt_desc_type head_desc;
   logic         head_pop;
   logic         q_empty;

   // Classify the request, advance the counter, compute the checksum.
   dlrf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_opcode     (req_opcode),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .wr_en          (wr_en),
      .wr_desc        (wr_desc)
   );

   // Hold classified requests until the serializer gets to them.
   dlrf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_desc (wr_desc),
      .rd_en   (head_pop),
      .rd_desc (head_desc),
      .q_full  (full),
      .q_empty (q_empty)
   );

   // Walk the head packet byte by byte, escape, and drive the response side.
   dlrf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (!q_empty),
      .head_desc    (head_desc),
      .head_pop     (head_pop),
      .pop          (pop),
      .empty        (empty),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

`ifndef NO_ASSERTIONS
   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> !q_empty)
      else $error("serializer released a packet from an empty queue");
   a_last_needs_head: assert property (@(posedge clock) disable iff (reset)
      (head_pop) |=> (!empty && rsp_last))
      else $error("packet release not marked by a last byte");
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!full && empty))
      else $error("block not idle after reset");
`endif

endmodule

>>> sim/tb.sv
// Self-checking bench for debug_link_request_framer: drives read and write requests,
// predicts the escaped wire bytes of each packet and checks every byte popped.
// Depends on dlrf_pkg and the framer RTL.
module tb import dlrf_pkg::*; ();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TIME  = 40;
   localparam int READS_NEEDED = 260;   // enough reads to wrap the 8-bit tag

   typedef struct packed {
      logic        opcode;
      logic [31:0] address;
      logic [31:0] data;
   } request_type;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } wire_byte_type;

   // Drive every input to a known value from time zero.
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        push           = 1'b0;
   logic        req_opcode     = OP_READ;
   logic [31:0] req_address    = '0;
   logic [31:0] req_write_data = '0;
   logic        pop            = 1'b0;
   logic        full;
   logic        empty;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;

   request_type   requests_to_send[$];
   wire_byte_type wire_bytes_due[$];
   logic [7:0]    read_seq;        // predicted request counter
   int            reads_queued;    // reads handed to the driver so far
   int            send_idle_pct;
   int            recv_stall_pct;
   int            n_fail;
   int            cycles;

   debug_link_request_framer DUT (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_opcode     (req_opcode),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Build the raw packet of one accepted request, then append its escaped
   // wire bytes to the queue of bytes due. Reads bump the tag before use.
   function automatic void frame_request(input request_type r);
      logic [7:0] raw[14];
      logic [7:0] sum;
      int         n;
      raw[0] = HDR_SYNC;
      raw[1] = HDR_ZERO;
      raw[3] = HDR_MARK;
      for (int i = 0; i < 4; i++) raw[5 + i] = r.address[8*i +: 8];
      if (r.opcode == OP_WRITE) begin
         raw[2] = LEN_WRITE;
         raw[4] = CMD_WRITE;
         for (int i = 0; i < 4; i++) raw[9 + i] = r.data[8*i +: 8];
         n = 14;
      end else begin
         read_seq = read_seq + 8'd1;
         raw[2] = LEN_READ;
         raw[4] = CMD_READ;
         raw[9] = read_seq;
         n = 11;
      end
      // Checksum covers the raw bytes from the FF mark up to the payload end.
      sum = 8'h00;
      for (int i = 3; i < n - 1; i++) sum = sum ^ raw[i];
      raw[n - 1] = sum;
      for (int i = 0; i < n; i++) begin
         if (raw[i] == XON_BYTE || raw[i] == XOFF_BYTE || raw[i] == ESC_BYTE) begin
            wire_bytes_due.push_back('{value: ESC_BYTE, last: 1'b0});
            wire_bytes_due.push_back('{value: raw[i] ^ ESC_FLIP, last: (i == n - 1)});
         end else begin
            wire_bytes_due.push_back('{value: raw[i], last: (i == n - 1)});
         end
      end
   endfunction

   // Favor bytes that need escaping, their flipped forms and the extremes.
   function automatic logic [7:0] pick_byte();
      logic [7:0] picks[9];
      picks = '{XON_BYTE, XOFF_BYTE, ESC_BYTE, 8'h00, 8'hFF,
                8'hEE, 8'hEC, 8'hA3, HDR_SYNC};
      if ($urandom_range(3) == 0) return picks[$urandom_range(8)];
      return 8'($urandom);
   endfunction

   task automatic queue_request(input logic op, input logic [31:0] addr,
                                input logic [31:0] data);
      requests_to_send.push_back('{opcode: op, address: addr, data: data});
      if (op == OP_READ) reads_queued++;
   endtask

   // Mostly reads so the tag wraps; content leans on escape-prone bytes.
   task automatic queue_random(input int count, input bit extend);
      logic [31:0] addr;
      logic [31:0] data;
      int          k;
      k = 0;
      while (k < count || (extend && reads_queued < READS_NEEDED)) begin
         addr = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
         data = ($urandom_range(1) == 0) ? 32'($urandom)
                                         : {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
         queue_request(($urandom_range(15) == 0) ? OP_WRITE : OP_READ, addr, data);
         k++;
      end
   endtask

   task automatic drain_requests();
      while (requests_to_send.size() != 0) @(posedge clock);
   endtask

   // Request driver: hold the offered request while full is high, advance on
   // acceptance, and idle at random between requests.
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            frame_request(requests_to_send.pop_front());
         end
         if (push && full) begin
            // hold request and payload until the framer takes it
         end else if (requests_to_send.size() != 0 &&
                      $urandom_range(99) >= send_idle_pct) begin
            push           <= 1'b1;
            req_opcode     <= requests_to_send[0].opcode;
            req_address    <= requests_to_send[0].address;
            req_write_data <= requests_to_send[0].data;
         end else begin
            push <= 1'b0;
         end
      end
   end

   // Response monitor: compare each popped byte with the oldest one due,
   // then decide at random whether to pop in the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (wire_bytes_due.size() == 0) begin
               $error("unexpected byte: rsp_out_byte=%h rsp_last=%b", rsp_out_byte, rsp_last);
               n_fail++;
            end else begin
               if (rsp_out_byte !== wire_bytes_due[0].value) begin
                  $error("rsp_out_byte: expected %h, actual %h",
                         wire_bytes_due[0].value, rsp_out_byte);
                  n_fail++;
               end
               if (rsp_last !== wire_bytes_due[0].last) begin
                  $error("rsp_last: expected %b, actual %b",
                         wire_bytes_due[0].last, rsp_last);
                  n_fail++;
               end
               void'(wire_bytes_due.pop_front());
            end
         end
         pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [7:0] tag;
      read_seq       = 8'h00;
      reads_queued   = 0;
      n_fail         = 0;
      cycles         = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: field extremes, both commands, escaping everywhere.
      queue_request(OP_READ,  32'h0000_0000, 32'h0000_0000);
      queue_request(OP_READ,  32'hFFFF_FFFF, 32'hFFFF_FFFF);  // data ignored on read
      queue_request(OP_WRITE, 32'h0000_0000, 32'h0000_0000);
      queue_request(OP_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(OP_WRITE, 32'h5C13_115C, 32'h1113_5C13);  // every payload byte escaped
      queue_request(OP_READ,  32'h5C13_1100, 32'hDEAD_BEEF);
      queue_request(OP_READ,  32'hA3EC_EE5C, 32'h0000_0000);  // flipped forms pass as is
      queue_request(OP_WRITE, 32'hA3EC_EEAD, 32'h5CA3_13EC);
      // Write checksums landing on each escape byte: 7D ^ 6C = 11, and so on.
      queue_request(OP_WRITE, 32'h0000_0000, 32'h0000_006C);
      queue_request(OP_WRITE, 32'h0000_0000, 32'h0000_006E);
      queue_request(OP_WRITE, 32'h0000_0000, 32'h0000_0021);
      // Read checksums landing on each escape byte, steered by the address LSB.
      tag = 8'(reads_queued + 1);
      queue_request(OP_READ, {24'h0, 8'hFD ^ tag ^ XON_BYTE}, 32'h0);
      tag = 8'(reads_queued + 1);
      queue_request(OP_READ, {24'h0, 8'hFD ^ tag ^ XOFF_BYTE}, 32'h0);
      tag = 8'(reads_queued + 1);
      queue_request(OP_READ, {24'h0, 8'hFD ^ tag ^ ESC_BYTE}, 32'h0);

      // Phase 1: back to back on both sides.
      queue_random(64, 1'b0);
      drain_requests();
      // Phase 2: sender idles often.
      send_idle_pct  = 59;
      recv_stall_pct = 0;
      queue_random(64, 1'b0);
      drain_requests();
      // Phase 3: receiver stalls often, queue fills and full rises.
      send_idle_pct  = 0;
      recv_stall_pct = 59;
      queue_random(64, 1'b0);
      drain_requests();
      // Phase 4: both sides idle now and then; extend until the tag wraps.
      send_idle_pct  = 14;
      recv_stall_pct = 14;
      queue_random(64, 1'b1);
      drain_requests();

      // Wait out the bytes still due, then let the pipeline settle.
      while (wire_bytes_due.size() != 0) @(posedge clock);
      repeat (SETTLE_TIME) @(posedge clock);
      if (wire_bytes_due.size() != 0) n_fail++;

      if (n_fail == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/dlrf_pkg.sv
src/dlrf_front.sv
src/dlrf_queue.sv
src/dlrf_back.sv
src/debug_link_request_framer.sv
sim/tb.sv
